>>> sv/mtr_pkg.sv
`default_nettype none
package mtr_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int ID_BITS     = 6;
  localparam int POS_BITS    = 7;
  localparam int WEIGHT_BITS = SCORE_BITS + 1;
  localparam int ECODE_BITS  = 2;

  localparam int EC_BITS   = 7;
  localparam int AC_BITS   = 4;
  localparam int BAND_BITS = 17;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] CFG_EXPERT_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_COUNT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCORE_BAND   = 2'd2;

  localparam logic [EC_BITS-1:0]   EC_RESET   = 7'd64;
  localparam logic [AC_BITS-1:0]   AC_RESET   = 4'd2;
  localparam logic [BAND_BITS-1:0] BAND_ONE   = 17'h10000;

  localparam logic [ECODE_BITS-1:0] ERR_NONE = 2'd0;
  localparam logic [ECODE_BITS-1:0] ERR_CFG  = 2'd1;
  localparam logic [ECODE_BITS-1:0] ERR_LEN  = 2'd2;

  localparam logic [POS_BITS-1:0] POS_MAX = 7'd127;

  typedef struct packed {
    logic insert;
    logic prep;
    logic sum_step;
    logic idx_clr;
    logic idx_inc;
    logic div_start;
    logic div_step;
    logic load_res;
    logic load_err;
  } cmd_t;

  typedef struct packed {
    logic [ECODE_BITS-1:0] err;
    logic n_zero;
    logic idx_last;
    logic idx_end;
    logic total_zero;
    logic cur_keep;
    logic cur_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> sv/mtr_if.sv
`default_nettype none
interface mtr_in_if;
  logic                           valid;
  logic                           ready;
  logic [mtr_pkg::SCORE_BITS-1:0] prob;
  logic                           row_end;
  modport source (output valid, output prob, output row_end, input ready);
  modport sink (input valid, input prob, input row_end, output ready);
endinterface

interface mtr_out_if;
  logic                            valid;
  logic                            ready;
  logic [mtr_pkg::ID_BITS-1:0]     expert_id;
  logic [mtr_pkg::WEIGHT_BITS-1:0] weight;
  logic                            last;
  logic [mtr_pkg::ECODE_BITS-1:0]  error_code;
  modport source (output valid, output expert_id, output weight, output last,
                  output error_code, input ready);
  modport sink (input valid, input expert_id, input weight, input last,
                input error_code, output ready);
endinterface
`default_nettype wire

>>> sv/mtr_ctrl.sv
`default_nettype none
module mtr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_row_end,
  output logic                  in_ready,
  input  wire mtr_pkg::status_t sts,
  output mtr_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.insert = 1'b1;
          if (in_row_end) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (sts.err != mtr_pkg::ERR_NONE) begin
          state_nxt = S_ERR;
        end else if (sts.n_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_SEL;
        end
      end
      S_SEL: begin
        if (sts.total_zero || sts.idx_end) begin
          state_nxt = S_IDLE;
        end else if (sts.cur_keep) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_res = 1'b1;
          if (sts.cur_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SEL;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> sv/mtr_dp.sv
`default_nettype none
module mtr_dp #(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_ACTIVE  = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [mtr_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  wire logic [mtr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic [mtr_pkg::SCORE_BITS-1:0]      in_prob,
  input  wire logic                                in_row_end,
  input  wire mtr_pkg::cmd_t                       cmd,
  output mtr_pkg::status_t                         sts,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic [mtr_pkg::ID_BITS-1:0]              out_expert_id,
  output logic [mtr_pkg::WEIGHT_BITS-1:0]          out_weight,
  output logic                                     out_last,
  output logic [mtr_pkg::ECODE_BITS-1:0]           out_error_code
);

  localparam int SB  = mtr_pkg::SCORE_BITS;
  localparam int QW  = mtr_pkg::WEIGHT_BITS;
  localparam int CW  = $clog2(MAX_ACTIVE + 1);
  localparam int IW  = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int SW  = SB + CW;
  localparam int TW  = 2 * SB + 1;
  localparam int QCW = $clog2(QW);

  logic [mtr_pkg::EC_BITS-1:0]   ec_r;
  logic [mtr_pkg::AC_BITS-1:0]   ac_r;
  logic [mtr_pkg::BAND_BITS-1:0] band_r;

  logic [SB-1:0]                 score_r [MAX_ACTIVE];
  logic [mtr_pkg::ID_BITS-1:0]   id_r    [MAX_ACTIVE];
  logic [CW-1:0]                 held_r;
  logic [mtr_pkg::POS_BITS-1:0]  pos_r;
  logic [CW-1:0]                 n_r;
  logic [mtr_pkg::ECODE_BITS-1:0] err_r;

  logic [TW-1:0]         thr_r;
  logic                  prune_en_r;
  logic [MAX_ACTIVE-1:0] keep_r;
  logic [SW-1:0]         total_r;
  logic [CW-1:0]         idx_r;
  logic [SW:0]           rem_r;
  logic [QW-1:0]         quo_r;
  logic [QCW-1:0]        cnt_r;

  logic                  out_valid_r;
  logic [mtr_pkg::ID_BITS-1:0]    out_id_r;
  logic [QW-1:0]                  out_weight_r;
  logic                           out_last_r;
  logic [mtr_pkg::ECODE_BITS-1:0] out_code_r;

  // Insertion into the sorted list, all positions compared at once.
  logic [CW-1:0]         lim, held_c, held_ins;
  logic [MAX_ACTIVE:0]   gx;
  logic [SB-1:0]         sc_ext [MAX_ACTIVE+1];
  logic [mtr_pkg::ID_BITS-1:0] id_ext [MAX_ACTIVE+1];
  logic [SB-1:0]         score_ins [MAX_ACTIVE];
  logic [mtr_pkg::ID_BITS-1:0] id_ins [MAX_ACTIVE];
  logic [mtr_pkg::ECODE_BITS-1:0] err_now;
  logic                  cfg_bad;

  always_comb begin
    if ({28'd0, ac_r} > 32'(MAX_ACTIVE)) lim = CW'(MAX_ACTIVE);
    else lim = CW'(ac_r);
    held_c = (held_r > lim) ? lim : held_r;
    held_ins = (held_c < lim) ? held_c + CW'(1) : held_c;
    gx[0]     = 1'b1;
    sc_ext[0] = '0;
    id_ext[0] = '0;
    for (int p = 0; p < MAX_ACTIVE; p++) begin
      gx[p+1]     = (p < int'(held_c)) && (score_r[p] >= in_prob);
      sc_ext[p+1] = score_r[p];
      id_ext[p+1] = id_r[p];
    end
    for (int p = 0; p < MAX_ACTIVE; p++) begin
      score_ins[p] = score_r[p];
      id_ins[p]    = id_r[p];
      if (p < int'(lim) && !gx[p+1]) begin
        if (gx[p]) begin
          score_ins[p] = in_prob;
          id_ins[p]    = pos_r[mtr_pkg::ID_BITS-1:0];
        end else begin
          score_ins[p] = sc_ext[p];
          id_ins[p]    = id_ext[p];
        end
      end
    end
    cfg_bad = (ec_r == '0) || ({25'd0, ec_r} > 32'(MAX_EXPERTS)) ||
              (ac_r == '0) || ({28'd0, ac_r} > 32'(MAX_ACTIVE)) ||
              ({3'd0, ac_r} > ec_r);
    if (cfg_bad) err_now = mtr_pkg::ERR_CFG;
    else if ({1'b0, pos_r} + 8'd1 != {1'b0, ec_r}) err_now = mtr_pkg::ERR_LEN;
    else err_now = mtr_pkg::ERR_NONE;
  end

  // Per-entry prune, keep and division signals.
  logic [SB-1:0] cur_w;
  logic          cur_pruned, cur_kp, more;
  logic          div_ge;
  logic [SW:0]   rem_sub;

  always_comb begin
    cur_w      = score_r[idx_r[IW-1:0]];
    cur_pruned = prune_en_r && ({1'b0, cur_w, {SB{1'b0}}} < thr_r);
    cur_kp     = !cur_pruned && (cur_w != '0);
    more       = 1'b0;
    for (int p = 0; p < MAX_ACTIVE; p++) begin
      if (p > int'(idx_r) && keep_r[p]) more = 1'b1;
    end
    div_ge  = rem_r >= {1'b0, total_r};
    rem_sub = div_ge ? rem_r - {1'b0, total_r} : rem_r;
  end

  always_comb begin
    sts            = '0;
    sts.err        = err_r;
    sts.n_zero     = (n_r == '0);
    sts.idx_last   = (idx_r + CW'(1) == n_r);
    sts.idx_end    = (idx_r >= n_r);
    sts.total_zero = (total_r == '0);
    sts.cur_keep   = keep_r[idx_r[IW-1:0]];
    sts.cur_last   = !more;
    sts.div_done   = (cnt_r == QCW'(QW - 1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_r   <= mtr_pkg::EC_RESET;
      ac_r   <= mtr_pkg::AC_RESET;
      band_r <= mtr_pkg::BAND_ONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        mtr_pkg::CFG_EXPERT_COUNT: ec_r   <= cfg_data[mtr_pkg::EC_BITS-1:0];
        mtr_pkg::CFG_ACTIVE_COUNT: ac_r   <= cfg_data[mtr_pkg::AC_BITS-1:0];
        mtr_pkg::CFG_SCORE_BAND:   band_r <= cfg_data[mtr_pkg::BAND_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pos_r  <= '0;
      n_r    <= '0;
      err_r  <= mtr_pkg::ERR_NONE;
      for (int p = 0; p < MAX_ACTIVE; p++) begin
        score_r[p] <= '0;
        id_r[p]    <= '0;
      end
    end else if (cmd.insert) begin
      for (int p = 0; p < MAX_ACTIVE; p++) begin
        score_r[p] <= score_ins[p];
        id_r[p]    <= id_ins[p];
      end
      if (in_row_end) begin
        held_r <= '0;
        pos_r  <= '0;
        n_r    <= held_ins;
        err_r  <= err_now;
      end else begin
        held_r <= held_ins;
        if (pos_r < mtr_pkg::POS_MAX) pos_r <= pos_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      thr_r      <= TW'(mtr_pkg::BAND_ONE - band_r) * TW'(score_r[0]);
      prune_en_r <= band_r < mtr_pkg::BAND_ONE;
      keep_r     <= '0;
      total_r    <= '0;
    end else if (cmd.sum_step) begin
      keep_r[idx_r[IW-1:0]] <= cur_kp;
      total_r <= total_r + (cur_kp ? SW'(cur_w) : SW'(0));
    end
    if (cmd.prep || cmd.idx_clr) idx_r <= '0;
    else if (cmd.sum_step || cmd.idx_inc) idx_r <= idx_r + CW'(1);
    // Restoring division, one quotient bit per cycle, MSB first.
    if (cmd.div_start) begin
      rem_r <= (SW + 1)'(cur_w);
      quo_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= {rem_sub[SW-1:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], div_ge};
      cnt_r <= cnt_r + QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_res || cmd.load_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_id_r     <= '0;
      out_weight_r <= '0;
      out_last_r   <= 1'b1;
      out_code_r   <= err_r;
    end else if (cmd.load_res) begin
      out_id_r     <= id_r[idx_r[IW-1:0]];
      out_weight_r <= quo_r;
      out_last_r   <= !more;
      out_code_r   <= mtr_pkg::ERR_NONE;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_expert_id  = out_id_r;
  assign out_weight     = out_weight_r;
  assign out_last       = out_last_r;
  assign out_error_code = out_code_r;

endmodule
`default_nettype wire

>>> sv/moe_topk_router_top.sv
// Top-k expert router for one mixture-of-experts token row.
// in_ch carries one Q0.16 expert score per beat; row_end marks the row's last
// score, and the expert number is the score's position in the row.
// out_ch carries result beats: expert_id, Q1.16 weight, last and error_code.
// Configuration (expert_count, active_count, pruning band) is written through
// cfg_we/cfg_idx/cfg_data while the router is idle; the user must keep to
// this; the router does not enforce it. A score that does not end a row is
// put in the sorted list as it is taken, against all kept entries at once.
// At row end the router stops taking beats: it checks the row and forms the
// pruning threshold, steps through every held entry to mark the kept ones
// and sum their weights, then selects each emitted expert, runs the 17-step
// restoring divider and loads the output; a skipped entry is passed over in select.
// An error row holds off the input until its single beat is loaded.
// The single output register holds a beat while out_ch.ready is low; the
// router then waits before loading the next result.
// Reset restores the configuration defaults, empties the kept list and
// clears the output valid.
`default_nettype none
module moe_topk_router_top #(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_ACTIVE  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  mtr_in_if.sink                                 in_ch,
  mtr_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [mtr_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  wire logic [mtr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  mtr_pkg::cmd_t    cmd;
  mtr_pkg::status_t sts;

  mtr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_row_end (in_ch.row_end),
    .in_ready   (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mtr_dp #(
    .MAX_EXPERTS (MAX_EXPERTS),
    .MAX_ACTIVE  (MAX_ACTIVE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_prob        (in_ch.prob),
    .in_row_end     (in_ch.row_end),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_expert_id  (out_ch.expert_id),
    .out_weight     (out_ch.weight),
    .out_last       (out_ch.last),
    .out_error_code (out_ch.error_code)
  );

endmodule
`default_nettype wire

>>> sv/mtr_checker.sv
`default_nettype none
module mtr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_row_end,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [mtr_pkg::ID_BITS-1:0]        expert_id,
  input wire logic [mtr_pkg::WEIGHT_BITS-1:0]    weight,
  input wire logic                               last,
  input wire logic [mtr_pkg::ECODE_BITS-1:0]     error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(expert_id) &&
    $stable(weight) && $stable(last) && $stable(error_code))
    else $error("result beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_code != mtr_pkg::ERR_NONE |->
    last && expert_id == '0 && weight == '0)
    else $error("error beat is not a lone zero beat");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> weight <= 17'h10000 &&
    (error_code == mtr_pkg::ERR_NONE || error_code == mtr_pkg::ERR_CFG ||
     error_code == mtr_pkg::ERR_LEN))
    else $error("weight or error code out of range");

  a_row_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_end |=> !in_ready)
    else $error("input taken right after row end");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind moe_topk_router_top mtr_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_row_end (in_ch.row_end),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .expert_id  (out_ch.expert_id),
  .weight     (out_ch.weight),
  .last       (out_ch.last),
  .error_code (out_ch.error_code)
);
`default_nettype wire
